[hw/rtl/zkc_pkg.sv]
// shared types and codes for the zone keep-in / keep-out checker
`timescale 1ns / 1ps

package zkc_pkg;

	// action codes
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_CHECK = 1'b1;

	// zone kinds
	localparam logic [1:0] KIND_KEEPOUT = 2'd0;
	localparam logic [1:0] KIND_KEEPIN  = 2'd1;
	localparam logic [1:0] KIND_CLUTTER = 2'd2;

	// result status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_KEEPOUT = 3'd1;
	localparam logic [2:0] ST_KEEPIN  = 3'd2;
	localparam logic [2:0] ST_SKIPPED = 3'd3;
	localparam logic [2:0] ST_LOADED  = 3'd4;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 5;
	localparam logic [CFG_IDX_W-1:0] CFG_KEEPIN_EN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEEPOUT_EN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ZONES_USED = 2'd2;

	// one setpoint in Q16.16 metres
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} point_t;

	// one zone table row: kind plus inclusive box corners
	typedef struct packed {
		logic [1:0] kind;
		point_t     lo;
		point_t     hi;
	} zone_t;

	localparam int ZONE_W = $bits(zone_t);

endpackage

[hw/rtl/zkc_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps

module zkc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/zkc_box_cmp.sv]
// shared compare unit: tests one point against one zone box on all three axes
`timescale 1ns / 1ps

module zkc_box_cmp (
	input  zkc_pkg::point_t pt,
	input  zkc_pkg::zone_t  zone,
	output logic            hit,
	output logic            is_keepout,
	output logic            is_keepin
);

	logic in_x;
	logic in_y;
	logic in_z;

	// inclusive bounds per axis; an inverted box never matches
	assign in_x = ($signed(pt.x) >= $signed(zone.lo.x)) && ($signed(pt.x) <= $signed(zone.hi.x));
	assign in_y = ($signed(pt.y) >= $signed(zone.lo.y)) && ($signed(pt.y) <= $signed(zone.hi.y));
	assign in_z = ($signed(pt.z) >= $signed(zone.lo.z)) && ($signed(pt.z) <= $signed(zone.hi.z));

	assign hit = in_x && in_y && in_z;

	// clutter and unknown kinds never count
	assign is_keepout = (zone.kind == zkc_pkg::KIND_KEEPOUT);
	assign is_keepin  = (zone.kind == zkc_pkg::KIND_KEEPIN);

endmodule

[hw/rtl/zone_keepin_keepout_check_core.sv]
// top level of the zone keep-in / keep-out checker: sequencer, table and result register
//
//   channel | direction | handshake            | payload
//   in      | to core   | in_valid / in_ready  | action, zone_slot, zone_kind, first_*, corner_*,
//           |           |                      | stamp, segment_start
//   out     | from core | out_valid / out_ready| status, stamp_echo
//   cfg     | to core   | cfg_we (no wait)     | cfg_index, cfg_data
//
// a load or a skipped check goes from idle straight to the finish state, which loads the output
// register and returns the sequencer to idle
// a check walks the table one zone per cycle through the ram read port in the scan state, then
// passes the tail, decide and finish states; n zones are read, n being zones_in_use clipped to
// MAX_ZONES, and with n zero the scan and tail states are skipped
// in_ready is high only while the sequencer is idle; a result held by out_ready low
// stalls the sequencer in its finish state
// arst_n clears control state and config; the zone table is not cleared
`timescale 1ns / 1ps

module zone_keepin_keepout_check_core #(
	parameter int MAX_ZONES = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             action,
	input  logic [3:0]                       zone_slot,
	input  logic [1:0]                       zone_kind,
	input  logic signed [31:0]               first_x,
	input  logic signed [31:0]               first_y,
	input  logic signed [31:0]               first_z,
	input  logic signed [31:0]               corner_x,
	input  logic signed [31:0]               corner_y,
	input  logic signed [31:0]               corner_z,
	input  logic [31:0]                      stamp,
	input  logic                             segment_start,
	// output channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [2:0]                       status,
	output logic [31:0]                      stamp_echo,
	// configuration port
	input  logic                             cfg_we,
	input  logic [zkc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [zkc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int AW = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
	localparam int NW = $clog2(MAX_ZONES + 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_TAIL   = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_FINISH = 3'd4;

	logic [2:0]            state_q;
	logic                  keepin_en_q;
	logic                  keepout_en_q;
	logic [4:0]            zones_used_q;
	logic                  seg_failed_q;
	logic [AW-1:0]         idx_q;
	logic [NW-1:0]         n_q;
	zkc_pkg::point_t       pt_q;
	logic [31:0]           stamp_q;
	logic [2:0]            res_q;
	logic                  in_keepout_q;
	logic                  in_keepin_q;
	logic                  rd_valid_s1;
	logic                  out_valid_q;
	logic [2:0]            status_q;
	logic [31:0]           stamp_echo_q;

	logic                  in_xfer;
	logic                  out_xfer;
	logic                  slot_ok;
	logic                  ram_we;
	logic                  ram_re;
	zkc_pkg::zone_t        wr_zone;
	logic [zkc_pkg::ZONE_W-1:0] rd_bits;
	zkc_pkg::zone_t        rd_zone;
	logic                  hit;
	logic                  is_keepout;
	logic                  is_keepin;
	logic [NW-1:0]         n_clip;
	logic                  last_idx;
	logic                  push_out;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid_q && out_ready;
	assign in_ready = (state_q == S_IDLE);

	// zone table write on load transfers to a slot inside the table
	assign slot_ok = (32'(zone_slot) < MAX_ZONES);
	assign ram_we  = in_xfer && (action == zkc_pkg::ACT_LOAD) && slot_ok;
	assign ram_re  = (state_q == S_SCAN);

	always_comb begin
		wr_zone.kind = zone_kind;
		wr_zone.lo.x = first_x;
		wr_zone.lo.y = first_y;
		wr_zone.lo.z = first_z;
		wr_zone.hi.x = corner_x;
		wr_zone.hi.y = corner_y;
		wr_zone.hi.z = corner_z;
	end

	zkc_ram #(
		.WIDTH (zkc_pkg::ZONE_W),
		.DEPTH (MAX_ZONES)
	) u_zone_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(zone_slot)),
		.wdata (wr_zone),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (rd_bits)
	);

	assign rd_zone = zkc_pkg::zone_t'(rd_bits);

	zkc_box_cmp u_box_cmp (
		.pt         (pt_q),
		.zone       (rd_zone),
		.hit        (hit),
		.is_keepout (is_keepout),
		.is_keepin  (is_keepin)
	);

	// zone count clipped to the table depth
	assign n_clip   = (32'(zones_used_q) > MAX_ZONES) ? NW'(MAX_ZONES) : NW'(zones_used_q);
	assign last_idx = (NW'(idx_q) == (n_q - NW'(1)));
	assign push_out = (state_q == S_FINISH) && (!out_valid_q || out_ready);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keepin_en_q  <= 1'b1;
			keepout_en_q <= 1'b1;
			zones_used_q <= 5'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				zkc_pkg::CFG_KEEPIN_EN:  keepin_en_q  <= cfg_data[0];
				zkc_pkg::CFG_KEEPOUT_EN: keepout_en_q <= cfg_data[0];
				zkc_pkg::CFG_ZONES_USED: zones_used_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			seg_failed_q <= 1'b0;
			idx_q        <= '0;
			rd_valid_s1  <= 1'b0;
		end else begin
			rd_valid_s1 <= ram_re;
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						idx_q <= '0;
						if (action == zkc_pkg::ACT_LOAD) begin
							state_q <= S_FINISH;
						end else if (seg_failed_q && !segment_start) begin
							state_q <= S_FINISH;
						end else begin
							seg_failed_q <= 1'b0;
							state_q      <= (n_clip == '0) ? S_DECIDE : S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (last_idx) begin
						state_q <= S_TAIL;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				S_TAIL: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if ((keepout_en_q && in_keepout_q) || (keepin_en_q && !in_keepin_q)) begin
						seg_failed_q <= 1'b1;
					end
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (push_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item registers and hit accumulators
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pt_q.x       <= first_x;
			pt_q.y       <= first_y;
			pt_q.z       <= first_z;
			stamp_q      <= stamp;
			n_q          <= n_clip;
			in_keepout_q <= 1'b0;
			in_keepin_q  <= 1'b0;
			if (action == zkc_pkg::ACT_LOAD) begin
				res_q <= zkc_pkg::ST_LOADED;
			end else begin
				res_q <= zkc_pkg::ST_SKIPPED;
			end
		end else if (rd_valid_s1) begin
			in_keepout_q <= in_keepout_q || (hit && is_keepout);
			in_keepin_q  <= in_keepin_q || (hit && is_keepin);
		end
		if (state_q == S_DECIDE) begin
			priority if (keepout_en_q && in_keepout_q) begin
				res_q <= zkc_pkg::ST_KEEPOUT;
			end else if (keepin_en_q && !in_keepin_q) begin
				res_q <= zkc_pkg::ST_KEEPIN;
			end else begin
				res_q <= zkc_pkg::ST_OK;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_out) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_out) begin
			status_q     <= res_q;
			stamp_echo_q <= stamp_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign stamp_echo = stamp_echo_q;

	// table reads stay within the zones in use
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (NW'(idx_q) < n_q))
		else $error("scan index past zone count");

	// read data only arrives while the table is being walked
	a_read_window: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> ((state_q == S_SCAN) || (state_q == S_TAIL)))
		else $error("zone read outside scan");

	// a new segment clears the failure flag before the decision
	a_seg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && (action == zkc_pkg::ACT_CHECK) && segment_start) |=> !seg_failed_q)
		else $error("segment start did not clear failure");

	// a decision always lands in the result stage
	a_decide_next: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE) |=> (state_q == S_FINISH))
		else $error("decide not followed by finish");

endmodule
